FILE: hw/rtl/rmwt_pkg.sv
// Shared constants, codes and types of the rainfall multi-window totalizer.
package rmwt_pkg;

   // Default history depth in five-minute bins (one day).
   localparam int unsigned NUM_BINS_DEFAULT = 288;

   localparam int unsigned BIN_W      = 8;
   localparam int unsigned RES_W      = 8;
   localparam int unsigned TOTAL_W    = 16;
   localparam int unsigned FUNC_W     = 2;

   // Eight window totals, the event total and two running totals.
   localparam int unsigned NUM_WIN    = 8;
   localparam int unsigned NUM_TOTALS = NUM_WIN + 3;
   localparam int unsigned TOT_IDX_W  = $clog2(NUM_TOTALS);

   // Exact sums kept for every window but the five-minute one.
   localparam int unsigned NUM_SUMS   = NUM_WIN - 1;
   localparam int unsigned SUM_IDX_W  = $clog2(NUM_SUMS);
   localparam int unsigned NUM_SHORT  = 6;

   // Places in the total file.
   localparam int unsigned TOT_5MIN   = 0;
   localparam int unsigned TOT_EVENT  = NUM_WIN;

   // The thirty-minute sum decides whether a rain event has ended.
   localparam int unsigned SUM_30MIN  = 1;

   localparam int unsigned REQ_DATA_W = 8;
   localparam int unsigned REQ_USER_W = FUNC_W;
   localparam int unsigned RSP_DATA_W = NUM_TOTALS * TOTAL_W;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_TIP   = 2'd0,
      FUNC_TICK  = 2'd1,
      FUNC_CLEAR = 2'd2,
      FUNC_FILL  = 2'd3
   } func_type;

   typedef enum logic {
      ALU_ADD = 1'b0,
      ALU_SUB = 1'b1
   } alu_op_type;

   // Operation handed to the shared adder.
   typedef struct packed {
      alu_op_type         op;
      logic [TOTAL_W-1:0] a;
      logic [TOTAL_W-1:0] b;
   } alu_req_type;

   // Lengths in bins of the fixed windows: 10 min, 30 min, 1 h, 3 h, 6 h, 12 h.
   function automatic int unsigned short_win_len(input logic [SUM_IDX_W-1:0] idx);
      int unsigned len;
      case (idx)
         3'd0:    len = 2;
         3'd1:    len = 6;
         3'd2:    len = 12;
         3'd3:    len = 36;
         3'd4:    len = 72;
         3'd5:    len = 144;
         default: len = 144;
      endcase
      return len;
   endfunction

endpackage

FILE: hw/rtl/rainfall_multi_window_totalizer_unit.sv
// Rainfall multi-window totalizer: top level with the request and response channels.
//
// Each request (tip, five-minute tick, clear or fill) returns one response holding all eleven
// 16-bit totals as they stand after the request. All arithmetic runs through one shared 16-bit
// adder stepped by a sequencer, and the block takes a single request at a time. A tip makes
// one saturating bin update and then eighteen total and sum updates through the adder. A tick
// reads the seven bins that leave their windows one after another from the bin memory and
// subtracts each from its running sum. Clear and fill write every bin, one per cycle. After
// reset the block runs a clearing pass over the bin memory before it accepts its first
// request; configuration writes are taken at any time.
// A finished response waits in an output register, so the next request is taken while it waits.
module rainfall_multi_window_totalizer_unit #(
   parameter int unsigned NUM_BINS = rmwt_pkg::NUM_BINS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // Request channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [rmwt_pkg::REQ_DATA_W-1:0]     req_tdata,   // [7:0] fill_value
   input  logic [rmwt_pkg::REQ_USER_W-1:0]     req_tuser,   // [1:0] func
   // Response channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [15:0] total_5min, [31:16] total_10min, [47:32] total_30min, [63:48] total_1h,
   // [79:64] total_3h, [95:80] total_6h, [111:96] total_12h, [127:112] total_24h,
   // [143:128] event_total, [159:144] running_total_a, [175:160] running_total_b
   output logic [rmwt_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // Configuration write channel
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [rmwt_pkg::RES_W-1:0]          csr_wdata    // resolution
);
   import rmwt_pkg::*;

   localparam int unsigned ADDR_W = $clog2(NUM_BINS);

   logic [RES_W-1:0]      resolution_ff;
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   logic                  out_free;
   logic                  out_load;
   logic [RSP_DATA_W-1:0] out_data;
   alu_req_type           alu_req;
   logic [TOTAL_W-1:0]    alu_result;
   logic                  ram_we;
   logic [ADDR_W-1:0]     ram_waddr;
   logic [BIN_W-1:0]      ram_wdata;
   logic [ADDR_W-1:0]     ram_raddr;
   logic [BIN_W-1:0]      ram_rdata;

   // Resolution register; always ready for a write.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         resolution_ff <= RES_W'(1);
      end else if (csr_valid) begin
         resolution_ff <= csr_wdata;
      end
   end

   // Output register between the sequencer and the response channel.
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_data_ff <= out_data;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   rmwt_ctrl #(
      .NUM_BINS (NUM_BINS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_func   (func_type'(req_tuser)),
      .req_fill   (req_tdata[BIN_W-1:0]),
      .resolution (resolution_ff),
      .out_free   (out_free),
      .out_load   (out_load),
      .out_data   (out_data),
      .alu_req    (alu_req),
      .alu_result (alu_result),
      .ram_we     (ram_we),
      .ram_waddr  (ram_waddr),
      .ram_wdata  (ram_wdata),
      .ram_raddr  (ram_raddr),
      .ram_rdata  (ram_rdata)
   );

   rmwt_alu u_alu (
      .alu_req    (alu_req),
      .alu_result (alu_result)
   );

   rmwt_bin_ram #(
      .NUM_BINS (NUM_BINS)
   ) u_bin_ram (
      .clock     (clock),
      .ram_we    (ram_we),
      .ram_waddr (ram_waddr),
      .ram_wdata (ram_wdata),
      .ram_raddr (ram_raddr),
      .ram_rdata (ram_rdata)
   );

endmodule

FILE: hw/rtl/rmwt_alu.sv
// Shared 16-bit add/subtract unit used for every total and sum update.
module rmwt_alu (
   input  rmwt_pkg::alu_req_type         alu_req,
   output logic [rmwt_pkg::TOTAL_W-1:0]  alu_result
);
   import rmwt_pkg::*;

   // Results wrap modulo 2^16.
   always_comb begin
      case (alu_req.op)
         ALU_ADD: alu_result = alu_req.a + alu_req.b;
         ALU_SUB: alu_result = alu_req.a - alu_req.b;
         default: alu_result = alu_req.a;
      endcase
   end

endmodule

FILE: hw/rtl/rmwt_bin_ram.sv
// Ring memory of five-minute rainfall bins, one write port and one registered read port.
module rmwt_bin_ram #(
   parameter  int unsigned NUM_BINS = rmwt_pkg::NUM_BINS_DEFAULT,
   localparam int unsigned ADDR_W   = $clog2(NUM_BINS)
) (
   input  logic                        clock,
   input  logic                        ram_we,
   input  logic [ADDR_W-1:0]           ram_waddr,
   input  logic [rmwt_pkg::BIN_W-1:0]  ram_wdata,
   input  logic [ADDR_W-1:0]           ram_raddr,
   output logic [rmwt_pkg::BIN_W-1:0]  ram_rdata
);
   import rmwt_pkg::*;

   logic [BIN_W-1:0] mem_ff [NUM_BINS];
   logic [BIN_W-1:0] rdata_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (ram_we) begin
         mem_ff[ram_waddr] <= ram_wdata;
      end
   end

   // Registered read port; a read in the cycle of a write to the same entry sees the old value.
   always_ff @(posedge clock) begin
      rdata_ff <= mem_ff[ram_raddr];
   end

   assign ram_rdata = rdata_ff;

endmodule

FILE: hw/rtl/rmwt_ctrl.sv
// Sequencer that drives the shared adder and the bin memory for tips, ticks, clear and fill.
module rmwt_ctrl #(
   parameter  int unsigned NUM_BINS = rmwt_pkg::NUM_BINS_DEFAULT,
   localparam int unsigned ADDR_W   = $clog2(NUM_BINS)
) (
   input  logic                             clock,
   input  logic                             reset,
   // Request side
   input  logic                             req_valid,
   output logic                             req_ready,
   input  rmwt_pkg::func_type               req_func,
   input  logic [rmwt_pkg::BIN_W-1:0]       req_fill,
   input  logic [rmwt_pkg::RES_W-1:0]       resolution,
   // Result hand-off to the output register
   input  logic                             out_free,
   output logic                             out_load,
   output logic [rmwt_pkg::RSP_DATA_W-1:0]  out_data,
   // Shared adder
   output rmwt_pkg::alu_req_type            alu_req,
   input  logic [rmwt_pkg::TOTAL_W-1:0]     alu_result,
   // Bin memory
   output logic                             ram_we,
   output logic [ADDR_W-1:0]                ram_waddr,
   output logic [rmwt_pkg::BIN_W-1:0]       ram_wdata,
   output logic [ADDR_W-1:0]                ram_raddr,
   input  logic [rmwt_pkg::BIN_W-1:0]       ram_rdata
);
   import rmwt_pkg::*;

   localparam int unsigned CNT_W = ADDR_W;
   localparam int unsigned LEN_W = $clog2(NUM_BINS + 1);

   typedef enum logic [2:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_TIP_SAT,
      ST_TIP_ADD,
      ST_TICK_DROP,
      ST_TICK_FIN,
      ST_DONE
   } state_type;

   state_type          state_ff;
   logic               init_ff;
   logic [BIN_W-1:0]   val_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [ADDR_W-1:0]  head_ff;
   logic [TOTAL_W-1:0] run_ff;
   logic [BIN_W-1:0]   delta_ff;
   logic [TOTAL_W-1:0] tot_ff [NUM_TOTALS];
   logic [TOTAL_W-1:0] sum_ff [NUM_SUMS];

   logic [TOT_IDX_W-1:0] tot_idx;
   logic [SUM_IDX_W-1:0] sum_idx;
   logic [CNT_W-1:0]     sum_cnt_in;
   logic                 tip_on_tot;
   logic [LEN_W-1:0]     sel_len;
   logic [LEN_W-1:0]     head_ext;
   logic [LEN_W-1:0]     drop_addr;
   logic [ADDR_W-1:0]    head_in;
   logic                 sat_carry;
   logic [BIN_W-1:0]     sat_bin;
   logic [BIN_W-1:0]     delta_in;

   // Window length in bins for each exact sum; the longest spans the whole history.
   function automatic logic [LEN_W-1:0] win_len(input logic [SUM_IDX_W-1:0] j);
      logic [LEN_W-1:0] len;
      if (j < SUM_IDX_W'(NUM_SHORT)) begin
         len = LEN_W'(short_win_len(j));
      end else begin
         len = LEN_W'(NUM_BINS);
      end
      return len;
   endfunction

   // Index decode for the total file and the exact sums.
   always_comb begin
      tot_idx    = cnt_ff[TOT_IDX_W-1:0];
      tip_on_tot = (cnt_ff < CNT_W'(NUM_TOTALS));
      if (state_ff == ST_TICK_DROP) begin
         sum_cnt_in = cnt_ff - CNT_W'(1);
      end else begin
         sum_cnt_in = cnt_ff - CNT_W'(NUM_TOTALS);
      end
      sum_idx = sum_cnt_in[SUM_IDX_W-1:0];
   end

   // Address of the bin that leaves window cnt on a tick (head already advanced).
   always_comb begin
      sel_len  = win_len(cnt_ff[SUM_IDX_W-1:0]);
      head_ext = LEN_W'(head_ff);
      if (head_ext >= sel_len) begin
         drop_addr = head_ext - sel_len;
      end else begin
         drop_addr = head_ext + (LEN_W'(NUM_BINS) - sel_len);
      end
   end

   // Next head position on a tick.
   assign head_in = (head_ff == ADDR_W'(NUM_BINS - 1)) ? '0 : head_ff + ADDR_W'(1);

   // Saturating bin update on a tip and the amount the bin really grew by.
   assign sat_carry = alu_result[BIN_W];
   assign sat_bin   = sat_carry ? '1 : alu_result[BIN_W-1:0];
   assign delta_in  = sat_carry ? ~ram_rdata : resolution;

   // Operand selection for the shared adder.
   always_comb begin
      alu_req.op = ALU_ADD;
      alu_req.a  = '0;
      alu_req.b  = '0;
      case (state_ff)
         ST_SWEEP: begin
            alu_req.a = (cnt_ff == '0) ? '0 : run_ff;
            alu_req.b = TOTAL_W'(val_ff);
         end
         ST_TIP_SAT: begin
            alu_req.a = TOTAL_W'(ram_rdata);
            alu_req.b = TOTAL_W'(resolution);
         end
         ST_TIP_ADD: begin
            if (tip_on_tot) begin
               alu_req.a = tot_ff[tot_idx];
               alu_req.b = TOTAL_W'(resolution);
            end else begin
               alu_req.a = sum_ff[sum_idx];
               alu_req.b = TOTAL_W'(delta_ff);
            end
         end
         ST_TICK_DROP: begin
            alu_req.op = ALU_SUB;
            if (cnt_ff != '0) begin
               alu_req.a = sum_ff[sum_idx];
               alu_req.b = TOTAL_W'(ram_rdata);
            end
         end
         default: begin
         end
      endcase
   end

   // Bin memory control.
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = head_ff;
      ram_wdata = '0;
      ram_raddr = head_ff;
      case (state_ff)
         ST_SWEEP: begin
            ram_we    = 1'b1;
            ram_waddr = cnt_ff[ADDR_W-1:0];
            ram_wdata = val_ff;
         end
         ST_TIP_SAT: begin
            ram_we    = 1'b1;
            ram_wdata = sat_bin;
         end
         ST_TICK_DROP: begin
            ram_raddr = drop_addr[ADDR_W-1:0];
         end
         ST_TICK_FIN: begin
            ram_we    = 1'b1;
            ram_wdata = '0;
         end
         default: begin
         end
      endcase
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign out_load  = (state_ff == ST_DONE) && out_free;

   // Result word, first total in the lowest bits.
   always_comb begin
      for (int i = 0; i < NUM_TOTALS; i++) begin
         out_data[i*TOTAL_W +: TOTAL_W] = tot_ff[i];
      end
   end

   // Sequencer state and the totals it keeps.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SWEEP;
         init_ff  <= 1'b1;
         val_ff   <= '0;
         cnt_ff   <= '0;
         head_ff  <= '0;
         for (int i = 0; i < NUM_TOTALS; i++) begin
            tot_ff[i] <= '0;
         end
         for (int j = 0; j < NUM_SUMS; j++) begin
            sum_ff[j] <= '0;
         end
      end else begin
         case (state_ff)
            // Write every bin with one value and build the window sums from it.
            ST_SWEEP: begin
               run_ff <= alu_result;
               for (int j = 0; j < NUM_SUMS; j++) begin
                  if (LEN_W'(cnt_ff) + LEN_W'(1) == win_len(SUM_IDX_W'(j))) begin
                     sum_ff[j] <= alu_result;
                  end
               end
               if (cnt_ff == CNT_W'(NUM_BINS - 1)) begin
                  cnt_ff  <= '0;
                  init_ff <= 1'b0;
                  state_ff <= init_ff ? ST_IDLE : ST_DONE;
               end else begin
                  cnt_ff <= cnt_ff + CNT_W'(1);
               end
            end

            // Dispatch a new request.
            ST_IDLE: begin
               cnt_ff <= '0;
               if (req_valid) begin
                  case (req_func)
                     FUNC_TIP: begin
                        state_ff <= ST_TIP_SAT;
                     end
                     FUNC_TICK: begin
                        head_ff  <= head_in;
                        state_ff <= ST_TICK_DROP;
                     end
                     FUNC_CLEAR: begin
                        val_ff <= '0;
                        for (int i = 0; i < NUM_TOTALS; i++) begin
                           tot_ff[i] <= '0;
                        end
                        state_ff <= ST_SWEEP;
                     end
                     FUNC_FILL: begin
                        val_ff   <= req_fill;
                        state_ff <= ST_SWEEP;
                     end
                     default: begin
                        state_ff <= ST_IDLE;
                     end
                  endcase
               end
            end

            // Newest bin has been read; store the saturated value.
            ST_TIP_SAT: begin
               delta_ff <= delta_in;
               state_ff <= ST_TIP_ADD;
            end

            // Add the resolution to every total, then the bin growth to every exact sum.
            ST_TIP_ADD: begin
               if (tip_on_tot) begin
                  tot_ff[tot_idx] <= alu_result;
               end else begin
                  sum_ff[sum_idx] <= alu_result;
               end
               if (cnt_ff == CNT_W'(NUM_TOTALS + NUM_SUMS - 1)) begin
                  state_ff <= ST_DONE;
               end else begin
                  cnt_ff <= cnt_ff + CNT_W'(1);
               end
            end

            // Read one leaving bin per cycle and take it off its sum in the next cycle.
            ST_TICK_DROP: begin
               if (cnt_ff != '0) begin
                  sum_ff[sum_idx] <= alu_result;
               end
               if (cnt_ff == CNT_W'(NUM_SUMS)) begin
                  state_ff <= ST_TICK_FIN;
               end else begin
                  cnt_ff <= cnt_ff + CNT_W'(1);
               end
            end

            // Publish the sums; a dry half hour ends the rain event.
            ST_TICK_FIN: begin
               tot_ff[TOT_5MIN] <= '0;
               for (int j = 0; j < NUM_SUMS; j++) begin
                  tot_ff[j + 1] <= sum_ff[j];
               end
               if (sum_ff[SUM_30MIN] == '0) begin
                  tot_ff[TOT_EVENT] <= '0;
               end
               state_ff <= ST_DONE;
            end

            // Wait for the output register to take the result.
            ST_DONE: begin
               if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end

            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

FILE: hw/rtl/rmwt_checker.sv
// Port-level checks of the totalizer and the bind that attaches them to the top level.
module rmwt_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [rmwt_pkg::RSP_DATA_W-1:0]  rsp_tdata
);
   import rmwt_pkg::*;

   logic       req_acc;
   logic       rsp_acc;
   logic [1:0] pend_ff;

   assign req_acc = req_tvalid && req_tready;
   assign rsp_acc = rsp_tvalid && rsp_tready;

   // Requests accepted whose response has not been taken yet.
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else if (req_acc && !rsp_acc) begin
         pend_ff <= pend_ff + 2'd1;
      end else if (rsp_acc && !req_acc) begin
         pend_ff <= pend_ff - 2'd1;
      end
   end

   // Reset leaves no response and starts the clearing pass.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && !req_tready)
      else $error("response or ready shown right after reset");

   // One request at a time: the block is busy right after taking one.
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> !req_tready)
      else $error("request taken while the previous one is still in work");

   // Every response belongs to a request, and at most two are in flight.
   a_resp_matches_req: assert property (@(posedge clock) disable iff (reset)
      (!rsp_tvalid || pend_ff != 2'd0) && pend_ff != 2'd3)
      else $error("response without a request or too many requests in flight");

   // A stalled response holds its totals.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

endmodule

bind rainfall_multi_window_totalizer_unit rmwt_checker u_rmwt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
